>>> rtl/daily_slot_trigger_matcher_assert.svh
// Assertion macros used by the slot trigger matcher RTL.
`ifndef DAILY_SLOT_TRIGGER_MATCHER_ASSERT_SVH
`define DAILY_SLOT_TRIGGER_MATCHER_ASSERT_SVH
`ifndef SYNTH
`define DSTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("immediate implication failed");
`define DSTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define DSTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DSTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dstm_pkg.sv
// Types, status codes and defaults for the slot trigger matcher.
`timescale 1ns / 1ps
package dstm_pkg;
	localparam int SLOT_COUNT_DEF = 16;
	localparam int ENTRY_W = 21;

	localparam logic [2:0] ST_INVALID  = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_NOMATCH  = 3'd2;
	localparam logic [2:0] ST_RECORDED = 3'd3;
	localparam logic [2:0] ST_NOROOM   = 3'd4;
	localparam logic [2:0] ST_REFUSED  = 3'd5;

	typedef struct packed {
		logic [4:0] current_day;
		logic [4:0] current_hour;
		logic [5:0] current_minute;
		logic [7:0] slot_number;
		logic [4:0] slot_hour;
		logic [5:0] slot_minute;
		logic       queue_accepts;
	} dstm_check_t;

	typedef struct packed {
		logic       dispense_fire;
		logic [7:0] dispense_slot;
		logic [2:0] check_status;
	} dstm_result_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} dstm_state_t;
endpackage

>>> rtl/dstm_if.sv
// Valid/ready channel interfaces for slot checks and their results.
`timescale 1ns / 1ps
interface dstm_check_if import dstm_pkg::*; ();
	logic        valid;
	logic        ready;
	dstm_check_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dstm_result_if import dstm_pkg::*; ();
	logic         valid;
	logic         ready;
	dstm_result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/daily_slot_trigger_matcher.sv
// Top level of the daily schedule-slot trigger matcher.
`timescale 1ns / 1ps
`include "daily_slot_trigger_matcher_assert.svh"
// After a slot check is accepted, the trigger records, which sit in a RAM
// with one read port, are read and compared one per cycle, followed by a
// compare drain state and a decision state; only then can the next check be
// accepted. A check with an invalid slot id skips the scan and goes straight
// to the decision state. A change of day clears all records at once through
// their valid bits. The result is held in an output register, so a new check
// is accepted while the last result waits.
module daily_slot_trigger_matcher
	import dstm_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dstm_check_if.sink    check,
	dstm_result_if.source result
);
	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	dstm_state_t           state_q;
	dstm_check_t           item_q;
	logic                  id_ok_q;
	logic [ENTRY_W-1:0]    key_q;
	logic                  hit_q;
	logic                  free_found_q;
	logic [AW-1:0]         free_idx_q;
	logic [AW-1:0]         idx_q;
	logic                  cmp_s1;
	logic [AW-1:0]         cmp_idx_s1;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [4:0]            last_day_q;
	logic                  out_valid_q;
	dstm_result_t          out_data_q;

	logic               accept;
	logic               id_ok;
	logic               time_match;
	logic               fire_w;
	logic               finish_load;
	logic               ram_we;
	logic [ENTRY_W-1:0] rdata;
	logic [2:0]         status_w;

	assign accept = check.valid && check.ready;
	assign check.ready = (state_q == S_IDLE);
	assign id_ok = (check.data.slot_number != 8'd0) &&
		(check.data.slot_number <= 8'(SLOT_COUNT));

	assign time_match = (item_q.current_hour == item_q.slot_hour) &&
		(item_q.current_minute == item_q.slot_minute);
	assign fire_w = id_ok_q && !hit_q && time_match && item_q.queue_accepts;
	assign finish_load = (state_q == S_FINISH) && (!out_valid_q || result.ready);
	assign ram_we = finish_load && fire_w && free_found_q;

	always_comb begin
		priority if (!id_ok_q) begin
			status_w = ST_INVALID;
		end else if (hit_q) begin
			status_w = ST_DONE;
		end else if (!time_match) begin
			status_w = ST_NOMATCH;
		end else if (!item_q.queue_accepts) begin
			status_w = ST_REFUSED;
		end else if (free_found_q) begin
			status_w = ST_RECORDED;
		end else begin
			status_w = ST_NOROOM;
		end
	end

	dstm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT),
		.ADDR_W(AW)
	) u_records (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(key_q),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			id_ok_q      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			idx_q        <= '0;
			cmp_s1       <= 1'b0;
			valid_q      <= '0;
			last_day_q   <= 5'd0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == S_SCAN);
			// The record addressed in the previous cycle is compared against the key now.
			if (cmp_s1 && valid_q[cmp_idx_s1] && (rdata == key_q)) begin
				hit_q <= 1'b1;
			end
			if (finish_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_ok_q      <= id_ok;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						idx_q        <= '0;
						if (check.data.current_day != last_day_q) begin
							valid_q    <= '0;
							last_day_q <= check.data.current_day;
						end
						state_q <= id_ok ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (idx_q == AW'(SLOT_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (finish_load) begin
						if (ram_we) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		if (accept) begin
			item_q <= check.data;
			key_q  <= {2'b00, check.data.slot_minute, check.data.slot_hour,
				check.data.slot_number};
		end
		if ((state_q == S_SCAN) && !valid_q[idx_q] && !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (finish_load) begin
			out_data_q.dispense_fire <= fire_w;
			out_data_q.dispense_slot <= fire_w ? item_q.slot_number : 8'd0;
			out_data_q.check_status  <= status_w;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	`DSTM_ASSERT_NEXT(a_invalid_skips_scan, clk, arst_n, accept && !id_ok,
		state_q == S_FINISH)
	`DSTM_ASSERT_IMPLY(a_fire_status, clk, arst_n, result.valid && result.data.dispense_fire,
		(result.data.check_status == ST_RECORDED) || (result.data.check_status == ST_NOROOM))
	`DSTM_ASSERT_IMPLY(a_hit_blocks_fire, clk, arst_n, (state_q == S_FINISH) && hit_q, !fire_w)
	`DSTM_ASSERT_NEXT(a_record_added, clk, arst_n, ram_we,
		$countones(valid_q) == $past($countones(valid_q)) + 1)
endmodule

>>> rtl/dstm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dstm_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
